// ===== hw/rtl/bounded_stack_with_session_gate_core_macros.svh =====
// Assertion macros for the stack RTL.
`ifndef BOUNDED_STACK_WITH_SESSION_GATE_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_SESSION_GATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define BSTK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSTK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSTK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BSTK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bstk_pkg.sv =====
// Types and constants of the bounded stack.
`default_nettype none

package bstk_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_PEEK  = 3'd3,
    OP_PURGE = 3'd4,
    OP_LIST  = 3'd5
  } op_t;

  // Status codes carried by a result.
  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_ALREADY_OPEN = 3'd1,
    STS_NOT_OPEN     = 3'd2,
    STS_OVERFLOW     = 3'd3,
    STS_UNDERFLOW    = 3'd4,
    STS_EMPTY        = 3'd5,
    STS_INVALID      = 3'd6
  } status_t;

  // Movement of the cell chain in one cycle.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_ROTATE = 2'd3
  } cell_cmd_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  // Control handed to each cell.
  typedef struct packed {
    cell_cmd_t cmd;
    logic      wrap;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bstk_cell.sv =====
// One storage cell of the stack chain.
`default_nettype none

module bstk_cell
  import bstk_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] push_in,
  input  wire logic [WORD_W-1:0] pop_in,
  input  wire logic [WORD_W-1:0] wrap_in,
  output logic      [WORD_W-1:0] data_out
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Push takes the word from above, pop from below; a rotate sends the top
  // word to the bottom cell so that a full listing restores the order.
  always_comb begin
    case (ctl.cmd)
      CMD_HOLD:   data_nxt = data_r;
      CMD_PUSH:   data_nxt = push_in;
      CMD_POP:    data_nxt = pop_in;
      CMD_ROTATE: data_nxt = ctl.wrap ? wrap_in : pop_in;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_stack_with_session_gate_core.sv =====
// Top level of the bounded stack with open/purge session gate.
`default_nettype none
`include "bounded_stack_with_session_gate_core_macros.svh"

// The stack is a chain of DEPTH word cells with the top at cell 0; every
// operation moves the whole chain by at most one place per cycle. Open, push,
// pop, peek, purge and invalid requests give one result each. A list request
// gives one result per stored element (one result if the stack is closed or
// empty) and holds off further requests until its last result is in the
// output register; the chain rotates one place per result so that the order
// is restored at the end. The single output register lets a new request in
// during the cycle the previous result is taken. A capacity above DEPTH acts
// as DEPTH.
module bounded_stack_with_session_gate_core
  import bstk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              open_r, open_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [CAP_W-1:0]  cap_r;
  cell_cmd_t         cmd;
  logic              slot_free;
  logic              full;
  logic [IW-1:0]     bottom_idx;
  logic [WORD_W-1:0] top_word;
  logic [WORD_W-1:0] cell_data [DEPTH];
  cell_ctl_t         cell_ctl  [DEPTH];

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Cell chain.
  assign top_word   = cell_data[0];
  assign bottom_idx = IW'(fill_r - CW'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctl[i].cmd  = cmd;
    assign cell_ctl[i].wrap = (bottom_idx == IW'(i));

    if (i == 0) begin : g_top
      bstk_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .push_in  (in_data.push_value),
        .pop_in   (cell_data[i+1]),
        .wrap_in  (top_word),
        .data_out (cell_data[i])
      );
    end else if (i == DEPTH - 1) begin : g_bot
      bstk_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .push_in  (cell_data[i-1]),
        .pop_in   (cell_data[i]),
        .wrap_in  (top_word),
        .data_out (cell_data[i])
      );
    end else begin : g_mid
      bstk_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .push_in  (cell_data[i-1]),
        .pop_in   (cell_data[i+1]),
        .wrap_in  (top_word),
        .data_out (cell_data[i])
      );
    end
  end

  // Overflow check against the capacity, capped at the chain length.
  assign full = (CMPW'(fill_r) >= CMPW'(cap_r)) || (fill_r == CW'(DEPTH));

  assign slot_free = !out_valid_r || !out_stall;

  // Next state, chain command and result.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd           = CMD_HOLD;
    in_stall      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = STS_OK;
          out_data_nxt.data   = '0;
          out_data_nxt.last   = 1'b1;
          case (in_data.operation)
            OP_OPEN: begin
              if (open_r) begin
                out_data_nxt.status = STS_ALREADY_OPEN;
              end else begin
                open_nxt = 1'b1;
              end
            end
            OP_PUSH: begin
              if (!open_r) begin
                out_data_nxt.status = STS_NOT_OPEN;
              end else if (full) begin
                out_data_nxt.status = STS_OVERFLOW;
              end else begin
                cmd      = CMD_PUSH;
                fill_nxt = fill_r + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (!open_r) begin
                out_data_nxt.status = STS_NOT_OPEN;
              end else if (fill_r == '0) begin
                out_data_nxt.status = STS_UNDERFLOW;
              end else begin
                out_data_nxt.data = top_word;
                if (in_data.operation == OP_POP) begin
                  cmd      = CMD_POP;
                  fill_nxt = fill_r - CW'(1);
                end
              end
            end
            OP_PURGE: begin
              if (!open_r) begin
                out_data_nxt.status = STS_NOT_OPEN;
              end else begin
                fill_nxt = '0;
                open_nxt = 1'b0;
              end
            end
            OP_LIST: begin
              if (!open_r || fill_r == '0) begin
                out_data_nxt.status = STS_EMPTY;
              end else begin
                out_data_nxt.data = top_word;
                out_data_nxt.last = (fill_r == CW'(1));
                cmd               = CMD_ROTATE;
                rem_nxt           = fill_r - CW'(1);
                if (fill_r != CW'(1)) begin
                  state_nxt = ST_LIST;
                end
              end
            end
            default: begin
              out_data_nxt.status = STS_INVALID;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = STS_OK;
          out_data_nxt.data   = top_word;
          out_data_nxt.last   = (rem_r == CW'(1));
          cmd                 = CMD_ROTATE;
          rem_nxt             = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rem_r       <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the controller.
  `BSTK_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(DEPTH),
    "fill count beyond chain length")
  `BSTK_ASSERT_IMP(a_closed_empty, clk, rst_n, !open_r, fill_r == '0,
    "closed stack holds elements")
  `BSTK_ASSERT_IMP(a_list_busy, clk, rst_n, state_r == ST_LIST,
    out_valid_r && in_stall && rem_r != '0, "listing without pending result")
  `BSTK_ASSERT_NXT(a_push_grows, clk, rst_n, cmd == CMD_PUSH,
    fill_r == $past(fill_r) + CW'(1), "push did not grow the stack")

endmodule

`default_nettype wire

// ===== tb/sv/bounded_stack_with_session_gate_core_tb.sv =====
// Self-checking testbench for the bounded stack with open/purge session gate.
`default_nettype none

module bounded_stack_with_session_gate_core_tb
  import bstk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 16;
  localparam int PHASE_ITEMS = 48;
  localparam int NUM_PHASES = 8;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // Tracks the stack contents and queues the results each request must produce.
  class stack_tracker;
    logic [CAP_W-1:0]   capacity;
    bit                 is_open;
    int unsigned        fill;
    logic signed [31:0] words [STACK_DEPTH];
    out_item_t          pending_results [$];
    int unsigned        mismatches;

    function void clear_state();
      capacity = CAP_RESET;
      is_open = 1'b0;
      fill = 0;
      pending_results.delete();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function void queue_result(status_t st, logic signed [31:0] word, logic is_last);
      out_item_t r;
      r.status = st;
      r.data = word;
      r.last = is_last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the tracked stack.
    function void note_request(in_item_t req);
      int unsigned limit;
      limit = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
      case (req.operation)
        OP_OPEN: begin
          if (is_open) begin
            queue_result(STS_ALREADY_OPEN, '0, 1'b1);
          end else begin
            is_open = 1'b1;
            queue_result(STS_OK, '0, 1'b1);
          end
        end
        OP_PUSH: begin
          if (!is_open) begin
            queue_result(STS_NOT_OPEN, '0, 1'b1);
          end else if (fill >= limit) begin
            queue_result(STS_OVERFLOW, '0, 1'b1);
          end else begin
            words[fill] = req.push_value;
            fill++;
            queue_result(STS_OK, '0, 1'b1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (!is_open) begin
            queue_result(STS_NOT_OPEN, '0, 1'b1);
          end else if (fill == 0) begin
            queue_result(STS_UNDERFLOW, '0, 1'b1);
          end else begin
            queue_result(STS_OK, words[fill-1], 1'b1);
            if (req.operation == OP_POP) fill--;
          end
        end
        OP_PURGE: begin
          if (!is_open) begin
            queue_result(STS_NOT_OPEN, '0, 1'b1);
          end else begin
            fill = 0;
            is_open = 1'b0;
            queue_result(STS_OK, '0, 1'b1);
          end
        end
        OP_LIST: begin
          if (!is_open || fill == 0) begin
            queue_result(STS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = fill; i > 0; i--) queue_result(STS_OK, words[i-1], i == 1);
          end
        end
        default: begin
          queue_result(STS_INVALID, '0, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("unexpected result: status %0d data %0h last %0d",
               got.status, got.data, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.data !== want.data) begin
        mismatches++;
        $error("data: expected %0h, actual %0h", want.data, got.data);
      end
      if (got.last !== want.last) begin
        mismatches++;
        $error("last: expected %0d, actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  stack_tracker tracker = new();
  bit           calm = 1'b0;
  int unsigned  pause_pct = 0;

  bounded_stack_with_session_gate_core #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid && !in_stall) tracker.note_request(in_data);
    if (rst_n === 1'b1 && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // Result-side back-pressure comes in random bursts until the final phase.
  initial begin
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
    in_valid <= 1'b1;
    in_data <= '{operation: op, push_value: value};
    do @(posedge clk); while (in_stall);
  endtask

  // Sometimes leave the request channel idle for a burst of cycles.
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < pause_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come back, plus a short margin.
  // An edge is awaited first so that the last accepted request has been noted.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity may only change while nothing is in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_capacity(value);
  endtask

  // Pushed words lean toward the sign and magnitude extremes.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly stack traffic; deep phases never purge and favor push over pop.
  function automatic logic [2:0] pick_operation(input bit deep);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return OP_OPEN;
    if (r < 9) return deep ? OP_PUSH : OP_PURGE;
    if (r < 11) return OP_RSVD_6;
    if (r < 13) return OP_RSVD_7;
    if (r < 23) return OP_LIST;
    if (r < 31) return OP_PEEK;
    return ($urandom_range(0, 99) < (deep ? 85 : 62)) ? OP_PUSH : OP_POP;
  endfunction

  // Main sequence: reset, directed corner cases, then capacity phases.
  initial begin
    logic [CAP_W-1:0] phase_caps [NUM_PHASES];
    bit               phase_deep [NUM_PHASES];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    tracker.clear_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Everything but open is refused while the stack is closed.
    send_request(OP_POP, 32'sd0);
    send_request(OP_PUSH, 32'sd5);
    send_request(OP_PEEK, 32'sd0);
    send_request(OP_PURGE, 32'sd0);
    send_request(OP_LIST, 32'sd0);
    send_request(OP_RSVD_6, 32'sd0);
    send_request(OP_RSVD_7, -32'sd1);
    // Opening twice, then the empty-stack cases.
    send_request(OP_OPEN, 32'sd0);
    send_request(OP_OPEN, 32'sd0);
    send_request(OP_LIST, 32'sd0);
    send_request(OP_POP, 32'sd0);
    send_request(OP_PEEK, 32'sd0);
    // Extreme words, then read them back.
    send_request(OP_PUSH, 32'sh7FFF_FFFF);
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PUSH, -32'sd1);
    send_request(OP_PUSH, 32'sd0);
    send_request(OP_PEEK, 32'sd0);
    send_request(OP_LIST, 32'sd0);
    send_request(OP_POP, 32'sd0);
    send_request(OP_LIST, 32'sd0);
    send_request(OP_RSVD_7, 32'sh5555_5555);
    // Purge closes the stack.
    send_request(OP_PURGE, 32'sd0);
    send_request(OP_LIST, 32'sd0);
    send_request(OP_POP, 32'sd0);

    // Full depth first, then shrink the capacity under a loaded stack.
    phase_caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd0, 5'd2, CAP_RESET};
    phase_deep = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_caps[5] = CAP_W'($urandom_range(1, 16));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: pause_pct = 0;
        1: pause_pct = 10;
        default: pause_pct = 40;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_pause();
        send_request(pick_operation(phase_deep[p]), pick_word());
      end
    end

    // Let the last results come out, then judge the run.
    drain_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
